// File: hdl/scra_pkg.sv
// Shared types and constants for the size-class region allocator.
// No dependencies; imported by the top level and the checker.
package scra_pkg;

  localparam int unsigned REGIONS     = 64;
  localparam int unsigned RIDX_W      = 6;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned NUM_BLOCKS  = 24;
  localparam int unsigned BID_W       = 5;
  localparam int unsigned BLK_W       = 3;
  localparam int unsigned MEM_W       = BID_W + RIDX_W;
  localparam int unsigned MEM_DEPTH   = NUM_BLOCKS * REGIONS;
  localparam int unsigned ADDR_W      = 29;
  localparam int unsigned SIZE_W      = 26;

  localparam logic [31:0] MIN_REQ_BYTES  = 32'd256;
  localparam logic [31:0] LARGE_BYTES    = 32'd33554432;
  localparam logic [31:0] SMALL_BYTES    = 32'd16384;
  localparam logic [31:0] MEDIUM_BYTES   = 32'd1048576;
  localparam logic [ADDR_W-1:0] MEDIUM_BASE = 29'd131072;
  localparam logic [ADDR_W-1:0] LARGE_BASE  = 29'd8519680;
  localparam logic [ADDR_W-1:0] MAP_END     = 29'd276955136;

  localparam logic [1:0] CLASS_SMALL  = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_LARGE  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_BIG     = 3'd1,
    ST_NO_MEM      = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_INVALID     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLOCK,
    S_STEP,
    S_PICK,
    S_FREE,
    S_FREE_APPLY,
    S_OUT,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic              req_type;
    logic [31:0]       alloc_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] grant_address;
  } rsp_t;

  // Mask of len low ones, len in 0..64.
  function automatic logic [REGIONS-1:0] run_mask(input logic [LEN_W-1:0] len);
    logic [REGIONS-1:0] m;
    if (len[LEN_W-1]) m = '1;
    else m = (64'(1) << len[RIDX_W-1:0]) - 64'(1);
    return m;
  endfunction

endpackage

// File: hdl/size_class_region_allocator.sv
// Allocate: block, step and pick states per visited block (up to 24 blocks); free: the
// free state and, if valid, free-apply; too-big to output; one transaction in flight.
// The run search shares one shift-and unit over the 7 bits of the region count.
// Throughput: next request accepted the cycle after the result transaction completes.
// Reset: all regions free, all blocks inactive; a clearing pass over all 1536 entries
// zeroes the run length memory before the first request is taken. Depends on scra_pkg.
module size_class_region_allocator import scra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  state_e state_q, state_d;

  logic [NUM_BLOCKS-1:0][REGIONS-1:0] map_q;
  logic [NUM_BLOCKS-1:0]              active_q;
  logic                               started_q;
  logic [LEN_W-1:0]                   run_mem [MEM_DEPTH];
  logic [LEN_W-1:0]                   rd_q;
  logic [MEM_W-1:0]                   clr_q;

  req_t              req_q;
  rsp_t              rsp_q;
  logic [SIZE_W-1:0] size_q;
  logic [1:0]        class_q;
  logic [BLK_W-1:0]  blk_q;
  logic [LEN_W-1:0]  need_q, cur_len_q;
  logic [2:0]        bit_q;
  logic [REGIONS-1:0] p_q, t_q;
  logic [BID_W-1:0]  fid_q;
  logic [RIDX_W-1:0] fidx_q;

  // Request front end
  logic       accept;
  logic [31:0] size_clamp;
  logic [1:0] start_class;
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign size_clamp = (in_data_i.alloc_bytes < MIN_REQ_BYTES) ? MIN_REQ_BYTES
                                                               : in_data_i.alloc_bytes;
  always_comb begin
    if (size_clamp <= SMALL_BYTES) start_class = CLASS_SMALL;
    else if (size_clamp <= MEDIUM_BYTES) start_class = CLASS_MEDIUM;
    else start_class = CLASS_LARGE;
  end

  // Search block id and region count for the current class
  logic [BID_W-1:0] sid;
  logic [LEN_W-1:0] need_calc;
  logic [SIZE_W:0]  need_sum;
  assign sid = {class_q, blk_q};
  always_comb begin
    unique case (class_q)
      CLASS_SMALL:  need_sum = (SIZE_W+1)'(size_q) + (SIZE_W+1)'(255);
      CLASS_MEDIUM: need_sum = (SIZE_W+1)'(size_q) + (SIZE_W+1)'(16383);
      default:      need_sum = (SIZE_W+1)'(size_q) + (SIZE_W+1)'(524287);
    endcase
    unique case (class_q)
      CLASS_SMALL:  need_calc = LEN_W'(need_sum >> 8);
      CLASS_MEDIUM: need_calc = LEN_W'(need_sum >> 14);
      default:      need_calc = LEN_W'(need_sum >> 19);
    endcase
  end

  // Shared shift-and unit: one bit of the region count per cycle
  logic              take_bit;
  logic [LEN_W-1:0]  step_len;
  assign take_bit = need_q[bit_q];
  assign step_len = LEN_W'(1) << bit_q;

  // Lowest window start
  logic [RIDX_W-1:0] pick_s;
  always_comb begin
    pick_s = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (t_q[i]) pick_s = RIDX_W'(i);
    end
  end

  logic [ADDR_W-1:0] grant_calc;
  always_comb begin
    unique case (class_q)
      CLASS_SMALL:  grant_calc = ADDR_W'({blk_q, pick_s, 8'b0});
      CLASS_MEDIUM: grant_calc = MEDIUM_BASE + ADDR_W'({blk_q, pick_s, 14'b0});
      default:      grant_calc = LARGE_BASE + ADDR_W'({blk_q, pick_s, 19'b0});
    endcase
  end

  // Free address decode
  logic [ADDR_W-1:0] faddr, foff;
  logic [BID_W-1:0]  fid;
  logic [RIDX_W-1:0] fidx;
  logic              fbad;
  assign faddr = req_q.free_address;
  always_comb begin
    foff = '0;
    fid  = '0;
    fidx = '0;
    fbad = 1'b0;
    priority if (faddr < MEDIUM_BASE) begin
      fid  = {CLASS_SMALL, faddr[16:14]};
      fidx = faddr[13:8];
      fbad = (faddr[7:0] != '0);
    end else if (faddr < LARGE_BASE) begin
      foff = faddr - MEDIUM_BASE;
      fid  = {CLASS_MEDIUM, foff[22:20]};
      fidx = foff[19:14];
      fbad = (foff[13:0] != '0);
    end else if (faddr < MAP_END) begin
      foff = faddr - LARGE_BASE;
      fid  = {CLASS_LARGE, foff[27:25]};
      fidx = foff[24:19];
      fbad = (foff[18:0] != '0);
    end else begin
      fbad = 1'b1;
    end
  end

  // An interior region reads a zero length, so the map stays as it is
  logic [REGIONS-1:0] free_map;
  assign free_map = map_q[fid_q] | (run_mask(rd_q) << fidx_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == MEM_W'(MEM_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.req_type == REQ_FREE) state_d = S_FREE;
          else if (size_clamp > LARGE_BYTES) state_d = S_OUT;
          else state_d = S_BLOCK;
        end
      end
      S_BLOCK: state_d = S_STEP;
      S_STEP:  if (bit_q == 3'd6) state_d = S_PICK;
      S_PICK: begin
        if (t_q != '0) state_d = S_OUT;
        else if (blk_q == '1 && class_q == CLASS_LARGE) state_d = S_OUT;
        else state_d = S_BLOCK;
      end
      S_FREE: begin
        if (fbad || !active_q[fid] || map_q[fid][fidx]) state_d = S_OUT;
        else state_d = S_FREE_APPLY;
      end
      S_FREE_APPLY: state_d = S_OUT;
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  // Advance the clearing address after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (state_q == S_CLEAR) clr_q <= clr_q + MEM_W'(1);
  end

  // Allocation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q     <= '1;
      active_q  <= '0;
      started_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && in_data_i.req_type == REQ_ALLOC && !started_q) begin
            started_q   <= 1'b1;
            active_q[0] <= 1'b1;
          end
        end
        S_BLOCK: active_q[sid] <= 1'b1;
        S_PICK: begin
          if (t_q != '0) begin
            map_q[sid] <= map_q[sid] & ~(run_mask(need_q) << pick_s);
          end
        end
        S_FREE_APPLY: begin
          map_q[fid_q] <= free_map;
          if (free_map == '1) active_q[fid_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Run length memory write port: clear, record a grant, drop a freed head
  logic             mem_we;
  logic [MEM_W-1:0] mem_waddr;
  logic [LEN_W-1:0] mem_wdata;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLEAR: mem_we = 1'b1;
      S_PICK: begin
        if (t_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = {sid, pick_s};
          mem_wdata = need_q;
        end
      end
      S_FREE_APPLY: begin
        mem_we    = 1'b1;
        mem_waddr = {fid_q, fidx_q};
      end
      default: ;
    endcase
  end

  // Run length memory
  always_ff @(posedge clk_i) begin
    if (mem_we) run_mem[mem_waddr] <= mem_wdata;
    rd_q <= run_mem[{fid, fidx}];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_q   <= in_data_i;
          size_q  <= SIZE_W'(size_clamp);
          class_q <= start_class;
          blk_q   <= '0;
          rsp_q   <= '{status: ST_TOO_BIG, grant_address: '0};
        end
      end
      S_BLOCK: begin
        need_q    <= need_calc;
        p_q       <= map_q[sid];
        t_q       <= '1;
        cur_len_q <= '0;
        bit_q     <= '0;
      end
      S_STEP: begin
        if (take_bit) begin
          t_q       <= t_q & (p_q >> cur_len_q);
          cur_len_q <= cur_len_q + step_len;
        end
        p_q   <= p_q & (p_q >> step_len);
        bit_q <= bit_q + 3'd1;
      end
      S_PICK: begin
        if (t_q != '0) begin
          rsp_q <= '{status: ST_OK, grant_address: grant_calc};
        end else begin
          rsp_q <= '{status: ST_NO_MEM, grant_address: '0};
          if (blk_q == '1) begin
            blk_q   <= '0;
            class_q <= class_q + 2'd1;
          end else begin
            blk_q <= blk_q + BLK_W'(1);
          end
        end
      end
      S_FREE: begin
        fid_q  <= fid;
        fidx_q <= fidx;
        priority if (fbad || !active_q[fid])
          rsp_q <= '{status: ST_INVALID, grant_address: '0};
        else if (map_q[fid][fidx])
          rsp_q <= '{status: ST_DOUBLE_FREE, grant_address: '0};
        else
          rsp_q <= '{status: ST_OK, grant_address: '0};
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

endmodule

// File: hdl/scra_checker.sv
// Port-level checks for the size-class region allocator.
// Depends on scra_pkg; bound to size_class_region_allocator.
module scra_checker import scra_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input rsp_t out_data_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed under stall");

  // Block new requests while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // Accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accept");

  // Grant address is zero unless status is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.grant_address == '0)
    else $error("nonzero grant on failure");

endmodule

bind size_class_region_allocator scra_checker u_scra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// File: tb/sv/size_class_region_allocator_checker.sv
// Checker for the size-class region allocator: watches both channels, predicts
// each response from its own copy of the allocator state, and counts mismatches.
// Depends on scra_pkg.
`timescale 1ns / 1ps
module size_class_region_allocator_checker import scra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  logic [REGIONS-1:0] free_map [NUM_BLOCKS];
  logic [LEN_W-1:0]   run_len  [MEM_DEPTH];
  logic [LEN_W-1:0]   free_cnt [NUM_BLOCKS];
  logic               active   [NUM_BLOCKS];
  logic               started;
  rsp_t               expected_rsp_q[$];
  int unsigned        errors;

  assign errors_o  = errors;
  assign pending_o = expected_rsp_q.size();

  function automatic longint unsigned class_bytes(input int c);
    if (c == CLASS_SMALL) return SMALL_BYTES;
    if (c == CLASS_MEDIUM) return MEDIUM_BYTES;
    return LARGE_BYTES;
  endfunction

  function automatic longint unsigned class_base(input int c);
    if (c == CLASS_SMALL) return 0;
    if (c == CLASS_MEDIUM) return MEDIUM_BASE;
    return LARGE_BASE;
  endfunction

  // First-fit search from the matching class upward.
  function automatic rsp_t alloc_run(input logic [31:0] bytes);
    rsp_t             r;
    longint unsigned  size, rb, need, run;
    int               c, b, k, id, s, hit;
    r = '0;
    if (!started) begin
      started = 1'b1;
      active[0] = 1'b1;
    end
    size = bytes;
    if (size < MIN_REQ_BYTES) size = MIN_REQ_BYTES;
    if (size > LARGE_BYTES) begin
      r.status = ST_TOO_BIG;
      return r;
    end
    if (size <= SMALL_BYTES) c = CLASS_SMALL;
    else if (size <= MEDIUM_BYTES) c = CLASS_MEDIUM;
    else c = CLASS_LARGE;
    for (; c < 3; c++) begin
      rb = class_bytes(c) / REGIONS;
      need = (size + rb - 1) / rb;
      for (b = 0; b < NUM_BLOCKS / 3; b++) begin
        id = c * (NUM_BLOCKS / 3) + b;
        run = 0;
        hit = -1;
        active[id] = 1'b1;
        for (k = 0; k < REGIONS; k++) begin
          run = free_map[id][k] ? run + 1 : 0;
          if (run >= need) begin
            hit = k;
            break;
          end
        end
        if (hit >= 0) begin
          s = hit + 1 - int'(need);
          for (k = s; k <= hit; k++) begin
            free_map[id][k] = 1'b0;
            run_len[id * REGIONS + k] = '0;
          end
          run_len[id * REGIONS + s] = LEN_W'(need);
          free_cnt[id] = free_cnt[id] - LEN_W'(need);
          r.status = ST_OK;
          r.grant_address = ADDR_W'(class_base(c) + b * class_bytes(c) + s * rb);
          return r;
        end
      end
    end
    r.status = ST_NO_MEM;
    return r;
  endfunction

  // Release the run headed at the given address.
  function automatic rsp_t free_run(input logic [ADDR_W-1:0] addr);
    rsp_t            r;
    longint unsigned off, blk_off, rb;
    int              c, b, id, i, last, k;
    r = '0;
    if (addr < MEDIUM_BASE) c = CLASS_SMALL;
    else if (addr < LARGE_BASE) c = CLASS_MEDIUM;
    else if (addr < MAP_END) c = CLASS_LARGE;
    else begin
      r.status = ST_INVALID;
      return r;
    end
    off = addr - class_base(c);
    b = int'(off / class_bytes(c));
    blk_off = off % class_bytes(c);
    rb = class_bytes(c) / REGIONS;
    id = c * (NUM_BLOCKS / 3) + b;
    if (!active[id] || (blk_off % rb) != 0 || (blk_off / rb) >= REGIONS) begin
      r.status = ST_INVALID;
      return r;
    end
    i = int'(blk_off / rb);
    if (free_map[id][i]) begin
      r.status = ST_DOUBLE_FREE;
      return r;
    end
    // An interior region has zero length here, so nothing is released.
    last = i + run_len[id * REGIONS + i];
    if (last > REGIONS) last = REGIONS;
    for (k = i; k < last; k++) begin
      if (!free_map[id][k]) begin
        free_map[id][k] = 1'b1;
        free_cnt[id] = free_cnt[id] + 1'b1;
      end
      run_len[id * REGIONS + k] = '0;
    end
    if (free_cnt[id] >= REGIONS) active[id] = 1'b0;
    r.status = ST_OK;
    return r;
  endfunction

  // Predict on accepted requests, compare accepted responses.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int n = 0; n < NUM_BLOCKS; n++) begin
        free_map[n] = '1;
        free_cnt[n] = LEN_W'(REGIONS);
        active[n]   = 1'b0;
      end
      for (int n = 0; n < MEM_DEPTH; n++) run_len[n] = '0;
      started = 1'b0;
      expected_rsp_q.delete();
      errors = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected response %h", $time, out_data_i);
        end else begin
          want = expected_rsp_q.pop_front();
          if (want.status !== out_data_i.status ||
              want.grant_address !== out_data_i.grant_address) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch status exp %0d got %0d, address exp %h got %h",
                       $time, want.status, out_data_i.status,
                       want.grant_address, out_data_i.grant_address);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == REQ_ALLOC) expected_rsp_q.push_back(alloc_run(in_data_i.alloc_bytes));
        else expected_rsp_q.push_back(free_run(in_data_i.free_address));
      end
    end
  end

endmodule

// File: tb/sv/size_class_region_allocator_tb.sv
// Testbench top for the size-class region allocator: clock, reset, request
// stimulus and response stalls; the checker module does the prediction.
// Depends on scra_pkg, size_class_region_allocator and its checker.
`timescale 1ns / 1ps
module size_class_region_allocator_tb;
  import scra_pkg::*;

  logic        clk_i, rst_ni;
  logic        in_valid, in_stall, out_valid, out_stall;
  req_t        in_data;
  rsp_t        out_data;
  int unsigned errors, pending;
  int unsigned tx_idle, rx_idle;
  bit          hold_req;
  int unsigned sent, received, n_alloc, n_free;
  logic        kind_q[$];
  logic [ADDR_W-1:0] live_q[$];
  logic [ADDR_W-1:0] last_freed;

  size_class_region_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  size_class_region_allocator_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Track live grants so frees can name real runs.
  always @(posedge clk_i) begin
    logic k;
    if (in_valid && !in_stall) kind_q.push_back(in_data.req_type);
    if (out_valid && !out_stall) begin
      received++;
      k = kind_q.pop_front();
      if (k == REQ_ALLOC && out_data.status == ST_OK) live_q.push_back(out_data.grant_address);
    end
  end

  // Random response stalls, with one long hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  // Cycle limit.
  initial begin
    repeat (3000000) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  task automatic send(input logic kind, input logic [31:0] bytes,
                      input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, alloc_bytes: bytes, free_address: addr};
    do @(posedge clk_i); while (in_stall);
    sent++;
    if (kind == REQ_ALLOC) n_alloc++;
    else n_free++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (received != sent) @(posedge clk_i);
  endtask

  initial begin
    int unsigned p, idx;
    logic [31:0] bytes;
    in_valid = 1'b0;
    in_data  = '0;
    tx_idle  = 25;
    rx_idle  = 77;
    hold_req = 1'b0;
    sent = 0; received = 0; n_alloc = 0; n_free = 0;
    last_freed = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first allocate, minimum sizes, class edges, oversize, no memory.
    send(REQ_ALLOC, 32'd0, '0);
    send(REQ_ALLOC, 32'd1, '0);
    send(REQ_ALLOC, 32'd256, '0);
    send(REQ_ALLOC, SMALL_BYTES, '0);
    send(REQ_ALLOC, SMALL_BYTES + 1, '0);
    send(REQ_ALLOC, MEDIUM_BYTES, '0);
    send(REQ_ALLOC, MEDIUM_BYTES + 1, '0);
    send(REQ_ALLOC, 32'hFFFF_FFFF, '0);
    send(REQ_ALLOC, LARGE_BYTES + 1, '0);
    repeat (8) send(REQ_ALLOC, LARGE_BYTES, '0);
    drain();
    // Directed frees: interior, misaligned, out of map, inactive, ok, double.
    send(REQ_FREE, '0, live_q[6] + 29'd524288);
    send(REQ_FREE, '0, live_q[6] + 29'd1);
    send(REQ_FREE, '0, 29'h1FFF_FFFF);
    send(REQ_FREE, '0, MAP_END);
    send(REQ_FREE, '0, MEDIUM_BASE + 29'd7340032);
    send(REQ_FREE, '0, live_q[6]);
    send(REQ_FREE, '0, live_q[0]);
    send(REQ_FREE, '0, live_q[0]);
    drain();
    live_q.delete(6);
    live_q.delete(0);

    // Random mix: mostly well-formed alloc/free pairs, some malformed frees.
    for (int n = 0; n < 1000; n++) begin
      if (n == 333) begin tx_idle = 77; rx_idle = 25; end
      if (n == 666) begin tx_idle = 0;  rx_idle = 0;  end
      if (n == 100) hold_req = 1'b1;
      if (n == 500) drain();
      p = $urandom_range(99);
      if (p < 50 || live_q.size() == 0) begin
        p = $urandom_range(99);
        if (p < 60) bytes = $urandom_range(SMALL_BYTES, 0);
        else if (p < 85) bytes = $urandom_range(MEDIUM_BYTES, SMALL_BYTES + 1);
        else if (p < 95) bytes = $urandom_range(LARGE_BYTES, MEDIUM_BYTES + 1);
        else bytes = $urandom;
        send(REQ_ALLOC, bytes, ADDR_W'($urandom));
      end else if (p < 88) begin
        idx = $urandom_range(live_q.size() - 1);
        last_freed = live_q[idx];
        live_q.delete(idx);
        send(REQ_FREE, $urandom, last_freed);
      end else begin
        case ($urandom_range(2))
          0: send(REQ_FREE, $urandom, ADDR_W'($urandom));
          1: send(REQ_FREE, $urandom,
                  ADDR_W'(live_q[$urandom_range(live_q.size() - 1)]
                          + $urandom_range(300, 1)));
          default: send(REQ_FREE, $urandom, last_freed);
        endcase
      end
    end
    drain();
    repeat (300) @(posedge clk_i);

    $display("Ran %0d requests: %0d allocates, %0d frees, under three stall mixes",
             sent, n_alloc, n_free);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
